FILE: hw/rtl/uvst_pkg.sv
package uvst_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_FIND   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_DUP   = 3'd1,
      STATUS_MISS  = 3'd2,
      STATUS_FULL  = 3'd3,
      STATUS_RANGE = 3'd4
   } status_type;

   typedef enum logic {
      STATE_IDLE    = 1'b0,
      STATE_RESOLVE = 1'b1
   } state_type;

   // per-cell control from the table controller
   typedef struct packed {
      logic load_hit;
      logic write_en;
      logic shift_en;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/unique_value_set_table.sv
// channel  | direction | transfer when           | payload
// req      | in        | req_valid & req_ready   | kind, value, index
// rsp      | out       | rsp_valid & rsp_ready   | status, position, data, count
//
// each request passes through a transfer cycle, in which every cell compares
// its entry with the value, and a resolve cycle that encodes the hit, appends or
// shifts the cells down, and loads the result register.
// the resolve cycle waits while an earlier result is still held on rsp.
// synchronous reset empties the table (count to zero); cell contents stay as they are.
module unique_value_set_table #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_position,
   output logic [31:0] rsp_data,
   output logic [6:0]  rsp_count
);
   import uvst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [5:0]             index_ff, index_in;
   logic [CNT_W-1:0]       count_ff, count_in, count_next;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [5:0]             rsp_position_ff, rsp_position_in;
   logic [31:0]            rsp_data_ff, rsp_data_in;
   logic [6:0]             rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   commit;
   logic [VALUE_WIDTH-1:0] cmp_key;
   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]    hit;
   logic [CAPACITY-1:0]    live;
   logic [CAPACITY-1:0]    hit_live;
   cell_ctl_type           ctl [CAPACITY];
   logic                   found;
   logic [IDX_W-1:0]       found_pos;
   logic                   full;
   logic                   insert_ok;
   logic                   remove_ok;
   logic                   read_ok;
   logic [IDX_W-1:0]       rd_addr;

   assign req_ready = (state_ff == STATE_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == STATE_RESOLVE) && (!rsp_valid_ff || rsp_ready);
   assign cmp_key   = VALUE_WIDTH'(req_value);

   // row of cells, each handing its entry to the one below on a remove
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] neighbour;

      if (g == CAPACITY - 1) begin : g_last
         assign neighbour = cell_value[g];
      end else begin : g_mid
         assign neighbour = cell_value[g + 1];
      end

      assign live[g]         = (CNT_W'(g) < count_ff);
      assign hit_live[g]     = hit[g] && live[g];
      assign ctl[g].load_hit = accept;
      assign ctl[g].write_en = commit && insert_ok && (CNT_W'(g) == count_ff);
      assign ctl[g].shift_en = commit && remove_ok && (IDX_W'(g) >= found_pos);

      uvst_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .cmp_key    (cmp_key),
         .wr_key     (key_ff),
         .next_value (neighbour),
         .value      (cell_value[g]),
         .hit        (hit[g])
      );
   end

   uvst_locate #(
      .CAPACITY (CAPACITY)
   ) u_locate (
      .hit      (hit_live),
      .found    (found),
      .position (found_pos)
   );

   always_comb begin
      full      = (count_ff == CNT_W'(CAPACITY));
      insert_ok = (kind_ff == KIND_INSERT) && !found && !full;
      remove_ok = (kind_ff == KIND_REMOVE) && found;
      read_ok   = (CMP_W'(index_ff) < CMP_W'(count_ff));
      rd_addr   = IDX_W'(index_ff);

      count_next = count_ff;
      if (insert_ok) begin
         count_next = count_ff + CNT_W'(1);
      end else if (remove_ok) begin
         count_next = count_ff - CNT_W'(1);
      end

      rsp_status_in   = STATUS_OK;
      rsp_position_in = '0;
      rsp_data_in     = '0;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (found) begin
               rsp_status_in   = STATUS_DUP;
               rsp_position_in = 6'(found_pos);
            end else if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               rsp_position_in = 6'(count_ff);
            end
         end
         KIND_REMOVE, KIND_FIND: begin
            if (found) begin
               rsp_position_in = 6'(found_pos);
            end else begin
               rsp_status_in = STATUS_MISS;
            end
         end
         KIND_READ: begin
            if (read_ok) begin
               rsp_position_in = index_ff;
               rsp_data_in     = 32'(cell_value[rd_addr]);
            end else begin
               rsp_status_in = STATUS_RANGE;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      rsp_count_in = 7'(count_next);

      count_in = commit ? count_next : count_ff;

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      kind_in  = accept ? kind_type'(req_kind) : kind_ff;
      key_in   = accept ? cmp_key : key_ff;
      index_in = accept ? req_index : index_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               state_in = STATE_RESOLVE;
            end
         end
         STATE_RESOLVE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      index_ff <= index_in;
      if (commit) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_position_ff <= rsp_position_in;
         rsp_data_ff     <= rsp_data_in;
         rsp_count_ff    <= rsp_count_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;

   // entries are distinct, so no more than one live cell may match
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_RESOLVE) |-> $onehot0(hit_live))
      else $error("more than one live entry matches");

   // the count moves only when a request is resolved
   assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(count_ff))
      else $error("entry count changed outside a resolve");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

endmodule

FILE: hw/rtl/uvst_cell.sv
module uvst_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  uvst_pkg::cell_ctl_type   ctl,
   input  logic [VALUE_WIDTH-1:0]   cmp_key,
   input  logic [VALUE_WIDTH-1:0]   wr_key,
   input  logic [VALUE_WIDTH-1:0]   next_value,
   output logic [VALUE_WIDTH-1:0]   value,
   output logic                     hit
);
   import uvst_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   hit_ff, hit_in;

   always_comb begin
      value_in = value_ff;
      hit_in   = hit_ff;
      // shifting down on a remove takes priority over an append
      if (ctl.shift_en) begin
         value_in = next_value;
      end else if (ctl.write_en) begin
         value_in = wr_key;
      end
      if (ctl.load_hit) begin
         hit_in = (value_ff == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

   assign value = value_ff;
   assign hit   = hit_ff;

endmodule

FILE: hw/rtl/uvst_locate.sv
module uvst_locate #(
   parameter int CAPACITY = 64
) (
   input  logic [CAPACITY-1:0]         hit,
   output logic                        found,
   output logic [$clog2(CAPACITY)-1:0] position
);
   import uvst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   // entries are distinct, so at most one live hit: an or of the indices suffices
   always_comb begin
      position = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         position = position | (hit[i] ? IDX_W'(i) : IDX_W'(0));
      end
      found = |hit;
   end

endmodule
